FILE: hdl/spf_pkg.sv
// shared types, constants and the crc-16 byte fold for the servo packet framer
// no dependencies; imported by every other file but spf_if and spf_checker
package spf_pkg;

  // command codes on the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PARAM = 1'b1;

  // header bytes and crc polynomial
  localparam logic [7:0]  HDR_SYNC  = 8'hff;
  localparam logic [7:0]  HDR_RSVD  = 8'hfd;
  localparam logic [7:0]  HDR_ZERO  = 8'h00;
  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam logic [15:0] LEN_EXTRA = 16'd3;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // byte sequencer step counter
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_HDR_LAST  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ZERO_LAST = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PARAM_LAST = 4'd2;

  typedef enum logic [2:0] {
    JOB_START,
    JOB_START_ZERO,
    JOB_PARAM,
    JOB_PARAM_LAST,
    JOB_ERR
  } job_kind_t;

  // one classified item; arg is param_count on start, param_byte on param
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] servo_id;
    logic [7:0] instruction;
    logic [7:0] arg;
  } job_t;

  // queue side of the handoff to the back end
  typedef struct packed {
    logic head_valid;
    job_t head;
  } q_head_t;

  // fold one byte into a non-reflected crc-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/spf_if.sv
// valid/ready channel interfaces for the framer's input and result streams
// no dependencies
interface spf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] servo_id;
  logic [7:0] instruction;
  logic [7:0] param_count;
  logic [7:0] param_byte;

  modport source (output valid, cmd, servo_id, instruction, param_count, param_byte,
                  input ready);
  modport sink   (input valid, cmd, servo_id, instruction, param_count, param_byte,
                  output ready);
endinterface

interface spf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;
  logic       status;

  modport source (output valid, out_byte, packet_end, run_last, status, input ready);
  modport sink   (input valid, out_byte, packet_end, run_last, status, output ready);
endinterface

FILE: hdl/spf_front.sv
// front end: accepts items, checks packet order and classifies them into jobs
// depends on spf_pkg and spf_in_if
module spf_front
  import spf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  spf_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  logic       in_packet_r, in_packet_nxt;
  logic [7:0] remain_r, remain_nxt;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // classify against the packet state and work out the next state
  always_comb begin
    in_packet_nxt        = in_packet_r;
    remain_nxt           = remain_r;
    push_job.servo_id    = in_ch.servo_id;
    push_job.instruction = in_ch.instruction;
    push_job.arg         = (in_ch.cmd == CMD_START) ? in_ch.param_count : in_ch.param_byte;
    push_job.kind        = JOB_ERR;
    if (in_ch.cmd == CMD_START) begin
      if (!in_packet_r) begin
        if (in_ch.param_count == 8'd0) begin
          push_job.kind = JOB_START_ZERO;
        end else begin
          push_job.kind = JOB_START;
          in_packet_nxt = 1'b1;
          remain_nxt    = in_ch.param_count;
        end
      end
    end else begin
      if (in_packet_r) begin
        if (remain_r == 8'd1) begin
          push_job.kind = JOB_PARAM_LAST;
          in_packet_nxt = 1'b0;
          remain_nxt    = 8'd0;
        end else begin
          push_job.kind = JOB_PARAM;
          remain_nxt    = remain_r - 8'd1;
        end
      end
    end
  end

  // packet state advances only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      remain_r    <= 8'd0;
    end else if (push) begin
      in_packet_r <= in_packet_nxt;
      remain_r    <= remain_nxt;
    end
  end

endmodule

FILE: hdl/spf_queue.sv
// short job queue that decouples the front end from the byte sequencer
// depends on spf_pkg
module spf_queue
  import spf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  output logic    full,
  input  logic    pop,
  output q_head_t q_head
);

  job_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign full              = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_head.head_valid = (cnt_r != '0);
  assign q_head.head       = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hdl/spf_back.sv
// back end: expands the head job into packet bytes, runs the crc, drives results
// depends on spf_pkg and spf_out_if
module spf_back
  import spf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  output logic      pop,
  spf_out_if.source out_ch
);

  logic [STEP_W-1:0] step_r;
  logic [15:0]       crc_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              packet_end_r, run_last_r, status_r;

  logic              fire;
  logic [STEP_W-1:0] last_step;
  logic [7:0]        cur_byte;
  logic              is_data, is_crc_hi, is_err;
  logic [15:0]       pkt_len;
  logic [15:0]       crc_base;

  assign pkt_len = {8'h00, q_head.head.arg} + LEN_EXTRA;
  assign fire    = q_head.head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = fire && (step_r == last_step);

  // byte selection for the current step of the head job
  always_comb begin
    cur_byte  = 8'h00;
    is_data   = 1'b0;
    is_crc_hi = 1'b0;
    is_err    = 1'b0;
    last_step = '0;
    case (q_head.head.kind)
      JOB_START, JOB_START_ZERO: begin
        last_step = (q_head.head.kind == JOB_START) ? STEP_HDR_LAST : STEP_ZERO_LAST;
        is_data   = (step_r <= STEP_HDR_LAST);
        case (step_r)
          4'd0:    cur_byte = HDR_SYNC;
          4'd1:    cur_byte = HDR_SYNC;
          4'd2:    cur_byte = HDR_RSVD;
          4'd3:    cur_byte = HDR_ZERO;
          4'd4:    cur_byte = q_head.head.servo_id;
          4'd5:    cur_byte = pkt_len[7:0];
          4'd6:    cur_byte = pkt_len[15:8];
          4'd7:    cur_byte = q_head.head.instruction;
          4'd8:    cur_byte = crc_r[7:0];
          default: begin
            cur_byte  = crc_r[15:8];
            is_crc_hi = 1'b1;
          end
        endcase
      end
      JOB_PARAM, JOB_PARAM_LAST: begin
        last_step = (q_head.head.kind == JOB_PARAM) ? '0 : STEP_PARAM_LAST;
        case (step_r)
          4'd0: begin
            cur_byte = q_head.head.arg;
            is_data  = 1'b1;
          end
          4'd1:    cur_byte = crc_r[7:0];
          default: begin
            cur_byte  = crc_r[15:8];
            is_crc_hi = 1'b1;
          end
        endcase
      end
      default: begin
        is_err = 1'b1;
      end
    endcase
  end

  // a new packet always starts the crc from zero
  assign crc_base = ((q_head.head.kind == JOB_START || q_head.head.kind == JOB_START_ZERO)
                     && step_r == '0) ? 16'h0000 : crc_r;

  // step counter, crc and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        step_r      <= (step_r == last_step) ? '0 : step_r + 1'b1;
        out_valid_r <= 1'b1;
        if (is_data) begin
          crc_r <= crc_fold(crc_base, cur_byte);
        end else if (is_crc_hi) begin
          crc_r <= 16'h0000;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r   <= cur_byte;
      packet_end_r <= is_crc_hi;
      run_last_r   <= (step_r == last_step);
      status_r     <= is_err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.packet_end = packet_end_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.status     = status_r;

endmodule

FILE: hdl/servo_packet_framer_crc16_unit.sv
// top level of the servo packet framer: front end, job queue and byte sequencer
// depends on spf_pkg, spf_if, spf_front, spf_queue and spf_back
//
// Turns start and parameter items into a framed instruction packet, one byte
// per result: header FF FF FD 00, id, length (count+3, low byte first),
// instruction, the parameter bytes, then a CRC-16 (poly 8005, non-reflected,
// init 0) low byte first, with packet_end on the last byte. An item out of
// order gives a single result with status set and no byte. The byte sequencer
// emits one result per cycle while a job is queued and the result channel takes
// them; a parameter item gives one result (three for the last one, which adds
// the CRC), a start item eight results and a start with zero count ten. A
// four-deep job queue lets input items be taken while earlier ones are still being expanded.
module servo_packet_framer_crc16_unit
  import spf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  spf_in_if.sink    in_ch,
  spf_out_if.source out_ch
);

  logic    push, q_full, pop;
  job_t    push_job;
  q_head_t q_head;

  // order check and classification
  spf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  spf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_head   (q_head)
  );

  // byte sequencer and crc
  spf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: hdl/spf_checker.sv
// port-level checks on the framer's result stream, bound to the top level
// depends on servo_packet_framer_crc16_unit
module spf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       packet_end,
  input logic       run_last,
  input logic       status
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an error item gives one result and carries no byte
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> run_last && !packet_end && out_byte == 8'h00)
    else $error("malformed error result");

  // the crc high byte always closes the item that caused it
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && packet_end |-> run_last && !status)
    else $error("packet end not on last result");

  // a packet end is followed by a header sync byte or an error, never data mid-packet
  a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && packet_end ##1 out_valid && !status
      |-> out_byte == 8'hff)
    else $error("bytes after packet end without a new header");

endmodule

bind servo_packet_framer_crc16_unit spf_checker u_spf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .packet_end (out_ch.packet_end),
  .run_last   (out_ch.run_last),
  .status     (out_ch.status)
);

FILE: bench/tb_top.sv
// self-checking bench for servo_packet_framer_crc16_unit: predicts the framed byte stream
// depends on spf_pkg, spf_if and the framer rtl; drives start and parameter items
// with random gaps and back-pressure and compares every result byte in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spf_pkg::*;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ORDER = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   CALM_FROM = 200;
  localparam int   CALM_TO   = 450;

  // one input item
  typedef struct {
    logic       cmd;
    logic [7:0] servo_id;
    logic [7:0] instruction;
    logic [7:0] param_count;
    logic [7:0] param_byte;
  } frame_req_t;

  // one result on the wire side
  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
    logic       status;
  } wire_byte_t;

  logic clk;
  logic rst_n;

  spf_in_if  in_ch ();
  spf_out_if out_ch ();

  servo_packet_framer_crc16_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_req_t pending_items[$];
  wire_byte_t wire_expect[$];
  frame_req_t held_item;

  // predictor state
  logic [15:0] crc_run;
  logic [7:0]  params_left;
  logic        pkt_open;

  int unsigned cyc;
  int unsigned mismatches;
  int unsigned items_taken;
  int unsigned bytes_checked;
  int unsigned packets_closed;
  int unsigned order_errors;

  // clock and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_START;
    in_ch.servo_id = 8'h00;
    in_ch.instruction = 8'h00;
    in_ch.param_count = 8'h00;
    in_ch.param_byte = 8'h00;
    out_ch.ready = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  initial cyc = 0;

  // random gap, off during the calm window
  function automatic bit gap_now(int unsigned at);
    if (at >= CALM_FROM && at < CALM_TO) begin
      return 1'b0;
    end
    return ($urandom_range(99) < 18);
  endfunction

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = c << 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic push_wire(logic [7:0] b, logic pend, logic last, logic st);
    wire_byte_t w;
    w.out_byte = b;
    w.packet_end = pend;
    w.run_last = last;
    w.status = st;
    wire_expect.push_back(w);
  endtask

  task automatic push_data(logic [7:0] b, logic last);
    crc_run = crc_step(crc_run, b);
    push_wire(b, 1'b0, last, ST_OK);
  endtask

  task automatic push_crc();
    push_wire(crc_run[7:0], 1'b0, 1'b0, ST_OK);
    push_wire(crc_run[15:8], 1'b1, 1'b1, ST_OK);
    crc_run = 16'h0000;
    pkt_open = 1'b0;
    params_left = 8'h00;
  endtask

  // expected bytes for one accepted item
  task automatic frame_bytes(frame_req_t r);
    logic [15:0] len;
    if (r.cmd == CMD_START) begin
      if (pkt_open) begin
        push_wire(8'h00, 1'b0, 1'b1, ST_ORDER);
        return;
      end
      len = {8'h00, r.param_count} + LEN_EXTRA;
      crc_run = 16'h0000;
      push_data(HDR_SYNC, 1'b0);
      push_data(HDR_SYNC, 1'b0);
      push_data(HDR_RSVD, 1'b0);
      push_data(HDR_ZERO, 1'b0);
      push_data(r.servo_id, 1'b0);
      push_data(len[7:0], 1'b0);
      push_data(len[15:8], 1'b0);
      push_data(r.instruction, r.param_count != 8'h00);
      if (r.param_count == 8'h00) begin
        push_crc();
      end else begin
        pkt_open = 1'b1;
        params_left = r.param_count;
      end
    end else begin
      if (!pkt_open) begin
        push_wire(8'h00, 1'b0, 1'b1, ST_ORDER);
        return;
      end
      push_data(r.param_byte, params_left != 8'h01);
      params_left = params_left - 8'h01;
      if (params_left == 8'h00) begin
        push_crc();
      end
    end
  endtask

  // driver: present queued items, predict on each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        items_taken++;
        frame_bytes(held_item);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && !gap_now(cyc)) begin
          held_item = pending_items.pop_front();
          in_ch.cmd <= held_item.cmd;
          in_ch.servo_id <= held_item.servo_id;
          in_ch.instruction <= held_item.instruction;
          in_ch.param_count <= held_item.param_count;
          in_ch.param_byte <= held_item.param_byte;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, check each accepted result
  always @(posedge clk) begin
    wire_byte_t got;
    wire_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte = out_ch.out_byte;
        got.packet_end = out_ch.packet_end;
        got.run_last = out_ch.run_last;
        got.status = out_ch.status;
        if (wire_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte=%02h end=%0b last=%0b st=%0b",
                                  got.out_byte, got.packet_end, got.run_last, got.status));
        end else begin
          want = wire_expect.pop_front();
          bytes_checked++;
          if (got.packet_end) packets_closed++;
          if (got.status == ST_ORDER) order_errors++;
          if (got != want) begin
            flag_mismatch($sformatf(
              "byte=%02h end=%0b last=%0b st=%0b, want byte=%02h end=%0b last=%0b st=%0b",
              got.out_byte, got.packet_end, got.run_last, got.status,
              want.out_byte, want.packet_end, want.run_last, want.status));
          end
        end
      end
      out_ch.ready <= !gap_now(cyc);
    end
  end

  task automatic add_start(logic [7:0] id, logic [7:0] instr, logic [7:0] cnt);
    frame_req_t r;
    r.cmd = CMD_START;
    r.servo_id = id;
    r.instruction = instr;
    r.param_count = cnt;
    r.param_byte = 8'($urandom);
    pending_items.push_back(r);
  endtask

  task automatic add_param(logic [7:0] b);
    frame_req_t r;
    r.cmd = CMD_PARAM;
    r.servo_id = 8'($urandom);
    r.instruction = 8'($urandom);
    r.param_count = 8'($urandom);
    r.param_byte = b;
    pending_items.push_back(r);
  endtask

  // stimulus, end of run and verdict
  initial begin
    int unsigned rand_items;
    int unsigned gen_left;
    int unsigned pick;
    logic [7:0]  cnt;

    mismatches = 0;
    items_taken = 0;
    bytes_checked = 0;
    packets_closed = 0;
    order_errors = 0;
    crc_run = 16'h0000;
    params_left = 8'h00;
    pkt_open = 1'b0;

    // directed: order errors, zero count, field extremes
    add_param(8'hff);
    add_start(8'h00, 8'h00, 8'h00);
    add_start(8'hff, 8'hff, 8'h00);
    add_start(8'h01, 8'h03, 8'h01);
    add_param(8'h00);
    add_start(8'haa, 8'h55, 8'h03);
    add_start(8'h12, 8'h34, 8'h00);
    add_param(8'hff);
    add_param(8'h5a);
    add_param(8'h00);
    add_param(8'h00);
    add_start(8'hfe, 8'h01, 8'h02);
    add_param(8'h80);
    add_param(8'h01);

    // random: mostly well-formed packets, some out-of-order noise
    rand_items = 0;
    gen_left = 0;
    while (rand_items < 190) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        if (gen_left == 0) add_param(8'($urandom));
        else add_start(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (gen_left == 0) begin
        pick = $urandom_range(99);
        if (pick < 15) cnt = 8'h00;
        else if (pick < 85) cnt = 8'($urandom_range(1, 6));
        else cnt = 8'($urandom_range(7, 12));
        add_start(8'($urandom), 8'($urandom), cnt);
        gen_left = cnt;
      end else begin
        add_param(8'($urandom));
        gen_left--;
      end
      rand_items++;
    end
    while (gen_left != 0) begin
      add_param(8'($urandom));
      gen_left--;
    end

    // a count of 253 sets the length high byte; that packet stays open at the end
    add_start(8'($urandom), 8'($urandom), 8'd253);
    repeat (4) add_param(8'($urandom));
    add_start(8'($urandom), 8'($urandom), 8'h00);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_ch.valid) @(posedge clk);
    while (wire_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wire_expect.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", wire_expect.size()));
    end

    $display("run covered %0d input items, %0d result bytes checked", items_taken,
             bytes_checked);
    $display("%0d packets closed by crc, %0d out-of-order results, %0d mismatches",
             packets_closed, order_errors, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
